// ===== sv/cspt_pkg.sv =====
`timescale 1ns / 1ps
package cspt_pkg;
	localparam int unsigned DIV_W = 52;
	localparam int unsigned DEN_W = 33;
	localparam int unsigned SQ_W = 58;
	localparam logic [15:0] SPEED_RESET = 16'd2511;
	localparam logic [16:0] SAFETY_RESET = 17'd65536;
	localparam logic [0:0] REG_SPEED = 1'b0;
	localparam logic [0:0] REG_SAFETY = 1'b1;
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;
	localparam logic [31:0] RADIUS_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] speed;
		logic [16:0] safety;
	} cspt_cfg_t;
endpackage

// ===== sv/cspt_serial_mul.sv =====
`timescale 1ns / 1ps
// Shift-and-add multiplier: one bit of b per cycle.
module cspt_serial_mul import cspt_pkg::*; #(
	parameter int unsigned A_W = 32,
	parameter int unsigned B_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic                 done,
	output logic [A_W+B_W-1:0]   prod
);
	localparam int unsigned CW = $clog2(B_W + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [A_W+B_W-1:0] a_sh_q;
	logic [B_W-1:0] b_q;

	assign prod = acc_q;

	// Each cycle adds the shifted multiplicand when the low bit of b is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				acc_q <= '0;
				a_sh_q <= {{B_W{1'b0}}, a};
				b_q <= b;
			end else if (busy_q) begin
				if (b_q[0]) acc_q <= acc_q + a_sh_q;
				a_sh_q <= a_sh_q << 1;
				b_q <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(B_W - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== sv/cspt_limit_unit.sv =====
`timescale 1ns / 1ps
// Velocity limit: serial products, a restoring divider and a bitwise root.
module cspt_limit_unit import cspt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cspt_cfg_t   cfg,
	input  logic [15:0] d,
	input  logic [15:0] w,
	input  logic [15:0] t,
	output logic        done,
	output logic [15:0] limit
);
	typedef enum logic [2:0] {
		S_IDLE, S_DEN, S_NUM, S_DIV, S_SQ, S_ROOT, S_SAFE
	} state_t;
	state_t state_q;

	logic [16:0] mag;
	assign mag = w[15] ? (17'h10000 - {1'b0, w}) : {1'b0, w};

	logic m_start_q, m_done;
	logic [31:0] m_a_q;
	logic [31:0] m_b_q;
	logic [63:0] m_p;
	cspt_serial_mul #(.A_W(32), .B_W(32)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start_q), .a(m_a_q), .b(m_b_q),
		.done(m_done), .prod(m_p)
	);

	logic [DEN_W-1:0] den_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W:0] rem_q;
	logic [5:0] cnt_q;
	logic [SQ_W+1:0] x_q;
	logic [29:0] root_q;
	logic [31:0] rrem_q;

	logic [DEN_W:0] rem_sh;
	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[DIV_W-1]};
	logic [31:0] trial;
	logic [31:0] rrem_sh;
	assign rrem_sh = {rrem_q[29:0], x_q[SQ_W+1:SQ_W]};
	assign trial = {root_q, 2'b01};

	// Sequencer: each step runs to completion before the next; the product steps share one serial multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			m_start_q <= 1'b0;
		end else begin
			done <= 1'b0;
			m_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					m_a_q <= {15'd0, mag};
					m_b_q <= {16'd0, t};
					m_start_q <= 1'b1;
					state_q <= S_DEN;
				end
				S_DEN: if (m_done) begin
					den_q <= m_p[DEN_W-1:0];
					m_a_q <= {16'd0, d};
					m_b_q <= 32'd4096000000;
					m_start_q <= 1'b1;
					state_q <= S_NUM;
				end
				S_NUM: if (m_done) begin
					quo_q <= m_p[DIV_W-1:0];
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				// Restoring division, one quotient bit per cycle.
				S_DIV: begin
					if (den_q == '0) begin
						m_a_q <= RADIUS_MAX;
						m_b_q <= {16'd0, cfg.speed} * 32'd1000;
						m_start_q <= 1'b1;
						state_q <= S_SQ;
					end else begin
						if (rem_sh >= {1'b0, den_q}) begin
							rem_q <= rem_sh - {1'b0, den_q};
							quo_q <= {quo_q[DIV_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DIV_W-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 6'(DIV_W - 1)) state_q <= S_SQ;
					end
				end
				// After the division the count stands at the quotient width.
				S_SQ: begin
					if (!m_start_q && cnt_q == 6'(DIV_W)) begin
						m_a_q <= (quo_q[DIV_W-1:32] != '0) ? RADIUS_MAX : quo_q[31:0];
						m_b_q <= {16'd0, cfg.speed} * 32'd1000;
						m_start_q <= 1'b1;
						cnt_q <= '0;
					end else if (m_done) begin
						x_q <= {4'd0, m_p[63:8]};
						root_q <= '0;
						rrem_q <= '0;
						cnt_q <= '0;
						state_q <= S_ROOT;
					end
				end
				// Digit-by-digit root, two radicand bits per cycle.
				S_ROOT: begin
					if (rrem_sh >= trial) begin
						rrem_q <= rrem_sh - trial;
						root_q <= {root_q[28:0], 1'b1};
					end else begin
						rrem_q <= rrem_sh;
						root_q <= {root_q[28:0], 1'b0};
					end
					x_q <= x_q << 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd29) state_q <= S_SAFE;
				end
				// After the root the count stands at the root width.
				S_SAFE: begin
					if (!m_start_q && cnt_q == 6'd30) begin
						m_a_q <= {2'b00, root_q};
						m_b_q <= {15'd0, cfg.safety};
						m_start_q <= 1'b1;
						cnt_q <= '0;
					end else if (m_done) begin
						limit <= (m_p[63:32] != '0) ? LIMIT_MAX : m_p[31:16];
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/curve_speed_profile_table.sv =====
`timescale 1ns / 1ps
// Record: four serial products, a 52-bit restoring divider and a 30-bit root, run
// one after another; the divider is skipped when the yaw rate or the period is zero.
// Query: the stored points are scanned in order, each one read and then compared,
// until a point lies beyond the query distance or the stored points run out.
// One item at a time: the input reopens the cycle after the result item is taken.
// Asynchronous active-low reset empties the table and restores register defaults.
module curve_speed_profile_table import cspt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        func,
	input  logic [15:0] step_distance,
	input  logic signed [15:0] yaw_rate,
	input  logic [15:0] sample_period,
	input  logic [31:0] query_distance,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] velocity,
	output logic [15:0] smallest_velocity,
	output logic        table_full,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_LIM, S_RD, S_CMP, S_OUT} state_t;
	state_t state_q;

	cspt_cfg_t cfg_q;
	logic [31:0] pos_mem [TABLE_DEPTH];
	logic [15:0] lim_mem [TABLE_DEPTH];
	logic [31:0] pos_rd_q;
	logic [15:0] lim_rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0] run_q;
	logic [15:0] min_q;
	logic [15:0] d_q;
	logic [15:0] w_q;
	logic [15:0] t_q;
	logic [31:0] qd_q;
	logic lim_start_q, lim_done;
	logic [15:0] lim;
	logic wr_en;
	logic [31:0] new_pos;
	logic [32:0] pos_sum;

	assign cfg_ready = 1'b1;
	assign ready = (state_q == S_IDLE);
	assign pos_sum = {1'b0, run_q} + {17'd0, d_q};
	assign new_pos = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
	assign wr_en = (state_q == S_LIM) && lim_done && (count_q < CW'(TABLE_DEPTH));

	cspt_limit_unit u_lim (
		.clk(clk), .arst_n(arst_n), .start(lim_start_q), .cfg(cfg_q),
		.d(d_q), .w(w_q), .t(t_q), .done(lim_done), .limit(lim)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed <= SPEED_RESET;
			cfg_q.safety <= SAFETY_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SPEED) cfg_q.speed <= cfg_data[15:0];
			else if (cfg_index == REG_SAFETY) cfg_q.safety <= cfg_data;
		end
	end

	// Table memories.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[count_q[AW-1:0]] <= new_pos;
			lim_mem[count_q[AW-1:0]] <= lim;
		end
		pos_rd_q <= pos_mem[idx_q[AW-1:0]];
		lim_rd_q <= lim_mem[idx_q[AW-1:0]];
	end

	// Item sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			lim_start_q <= 1'b0;
			count_q <= '0;
			run_q <= '0;
			min_q <= LIMIT_MAX;
		end else begin
			lim_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (valid) begin
					d_q <= step_distance;
					w_q <= yaw_rate;
					t_q <= sample_period;
					qd_q <= query_distance;
					idx_q <= '0;
					if (func == FUNC_RECORD) begin
						lim_start_q <= 1'b1;
						state_q <= S_LIM;
					end else begin
						state_q <= S_RD;
					end
				end
				S_LIM: if (lim_done) begin
					velocity <= lim;
					table_full <= !wr_en;
					if (wr_en) begin
						run_q <= new_pos;
						count_q <= count_q + 1'b1;
						if (lim < min_q) min_q <= lim;
						smallest_velocity <= (lim < min_q) ? lim : min_q;
					end else begin
						smallest_velocity <= min_q;
					end
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_RD: begin
					if (idx_q >= count_q) begin
						velocity <= '0;
						table_full <= 1'b0;
						smallest_velocity <= min_q;
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (pos_rd_q > qd_q) begin
						velocity <= lim_rd_q;
						table_full <= 1'b0;
						smallest_velocity <= min_q;
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/cspt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the result channel.
module cspt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] velocity,
	input logic [15:0] smallest_velocity,
	input logic        table_full
);
	// A stalled result item keeps its valid and its whole payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		out_valid && $stable({velocity, smallest_velocity, table_full}))
		else $error("result changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && ready))
		else $error("input open while a result waits");
	// Any stored or looked-up limit is at least the running minimum.
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !table_full && velocity != 16'd0 |->
		smallest_velocity <= velocity)
		else $error("minimum above a stored limit");
endmodule

bind curve_speed_profile_table cspt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .ready(ready), .out_valid(out_valid),
	.out_ready(out_ready), .velocity(velocity),
	.smallest_velocity(smallest_velocity), .table_full(table_full)
);
